[sv/ppm_pkg.sv]
// Shared constants, codes and types of the PPM channel decoder.
package ppm_pkg;

    localparam int CHANNELS     = 8;
    localparam int PULSE_BITS   = 24;
    localparam int REG_BITS     = 24;
    localparam int CMP_BITS     = (PULSE_BITS > REG_BITS) ? PULSE_BITS : REG_BITS;
    localparam int SLOT_BITS    = $clog2(CHANNELS + 1);
    localparam int CHAN_BITS    = 3;
    localparam int POS_BITS     = 5;
    localparam int SW_BITS      = 2;
    localparam int CFG_IDX_BITS = 3;

    localparam int POS_STEP   = 2400;
    localparam int POS_MAX    = 31;
    localparam int POS_SAT    = POS_MAX * POS_STEP;
    localparam int DIFF_BITS  = $clog2(POS_SAT);
    localparam int POS_SHIFT  = 30;
    localparam int POS_RECIP  = ((2 ** POS_SHIFT) + POS_STEP - 1) / POS_STEP;
    localparam int RECIP_BITS = $clog2(POS_RECIP + 1);
    localparam int PROD_BITS  = DIFF_BITS + RECIP_BITS;

    localparam logic [REG_BITS-1:0] SYNC_THRESHOLD_RST = REG_BITS'(50000);
    localparam logic [REG_BITS-1:0] CLAMP_LOW_RST      = REG_BITS'(24000);
    localparam logic [REG_BITS-1:0] CLAMP_HIGH_RST     = REG_BITS'(48000);
    localparam logic [REG_BITS-1:0] SWITCH_LOW_RST     = REG_BITS'(32000);
    localparam logic [REG_BITS-1:0] SWITCH_HIGH_RST    = REG_BITS'(40000);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SYNC_THRESHOLD = 3'd0,
        REG_CLAMP_LOW      = 3'd1,
        REG_CLAMP_HIGH     = 3'd2,
        REG_SWITCH_LOW     = 3'd3,
        REG_SWITCH_HIGH    = 3'd4
    } reg_index_t;

    typedef enum logic [SW_BITS-1:0] {
        SW_DOWN   = 2'd0,
        SW_MIDDLE = 2'd1,
        SW_UP     = 2'd2
    } switch_t;

    typedef struct packed {
        logic [REG_BITS-1:0] sync_threshold;
        logic [REG_BITS-1:0] clamp_low;
        logic [REG_BITS-1:0] clamp_high;
        logic [REG_BITS-1:0] switch_low;
        logic [REG_BITS-1:0] switch_high;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0]  channel;
        logic [PULSE_BITS-1:0] width;
    } chan_item_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] channel;
        logic [REG_BITS-1:0]  raw_width;
        logic [REG_BITS-1:0]  clamped_width;
        logic                 below_low;
        logic [POS_BITS-1:0]  position;
        switch_t              switch_state;
    } result_t;

endpackage

[sv/ppm_channel_decoder.sv]
// Top level of the PPM channel decoder: configuration registers and the two halves.
// Takes one captured pulse width per cycle on in_valid/in_ready. A width above
// sync_threshold starts a frame; the next eight widths become channels 0 to 7, each
// giving one result with the raw width, the width clamped to clamp_low..clamp_high,
// a below-low flag, a 0..31 position in steps of 2400 ticks and a switch reading.
// Pulses outside a frame and sync pulses give no result. A result passes through
// the queue, the pipeline stage and the output register before it is valid. The
// input accepts one width every cycle as long as the two-entry queue between the
// classifier and the arithmetic pipeline has room; with the output stalled, up to
// four channel pulses wait inside (two in the queue, one in the pipeline stage, one
// in the output register) and the input holds once the queue is full.
// Write the configuration registers only while no pulse is in flight.
module ppm_channel_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ppm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ppm_pkg::REG_BITS-1:0]     cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ppm_pkg::PULSE_BITS-1:0]   pulse_width,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ppm_pkg::CHAN_BITS-1:0]    channel,
    output logic [ppm_pkg::REG_BITS-1:0]     raw_width,
    output logic [ppm_pkg::REG_BITS-1:0]     clamped_width,
    output logic                             below_low,
    output logic [ppm_pkg::POS_BITS-1:0]     position,
    output logic [ppm_pkg::SW_BITS-1:0]      switch_state
);
    import ppm_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       q_full;
    logic       q_push;
    chan_item_t q_push_item;
    logic       q_pop;
    logic       q_valid;
    chan_item_t q_pop_item;
    result_t    result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_THRESHOLD: cfg_next.sync_threshold = cfg_data;
                REG_CLAMP_LOW:      cfg_next.clamp_low      = cfg_data;
                REG_CLAMP_HIGH:     cfg_next.clamp_high     = cfg_data;
                REG_SWITCH_LOW:     cfg_next.switch_low     = cfg_data;
                REG_SWITCH_HIGH:    cfg_next.switch_high    = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_threshold <= SYNC_THRESHOLD_RST;
            cfg_reg.clamp_low      <= CLAMP_LOW_RST;
            cfg_reg.clamp_high     <= CLAMP_HIGH_RST;
            cfg_reg.switch_low     <= SWITCH_LOW_RST;
            cfg_reg.switch_high    <= SWITCH_HIGH_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    ppm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pulse_width (pulse_width),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_push_item)
    );

    ppm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_pop_item)
    );

    ppm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_pop_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign channel       = result.channel;
    assign raw_width     = result.raw_width;
    assign clamped_width = result.clamped_width;
    assign below_low     = result.below_low;
    assign position      = result.position;
    assign switch_state  = result.switch_state;

endmodule

[sv/ppm_front.sv]
// Front end: takes pulse widths, tracks the frame slot and queues channel pulses.
module ppm_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ppm_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ppm_pkg::PULSE_BITS-1:0] pulse_width,
    input  logic                           q_full,
    output logic                           q_push,
    output ppm_pkg::chan_item_t            q_item
);
    import ppm_pkg::*;

    logic [SLOT_BITS-1:0] slot_reg;
    logic [SLOT_BITS-1:0] slot_next;
    logic [SLOT_BITS-1:0] slot_idx;
    logic                 accept;
    logic                 is_sync;
    logic                 in_frame;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_sync  = CMP_BITS'(pulse_width) > CMP_BITS'(cfg.sync_threshold);
    assign in_frame = (slot_reg != '0) && (slot_reg <= SLOT_BITS'(CHANNELS));
    assign slot_idx = slot_reg - SLOT_BITS'(1);

    assign q_push         = accept && !is_sync && in_frame;
    assign q_item.channel = CHAN_BITS'(slot_idx);
    assign q_item.width   = pulse_width;

    always_comb
    begin
        slot_next = slot_reg;
        if (accept)
        begin
            if (is_sync)
                slot_next = SLOT_BITS'(1);
            else if (!in_frame || slot_reg >= SLOT_BITS'(CHANNELS))
                slot_next = '0;
            else
                slot_next = slot_reg + SLOT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else
            slot_reg <= slot_next;
    end

endmodule

[sv/ppm_queue.sv]
// Two-entry queue between the front end and the back end.
module ppm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ppm_pkg::chan_item_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output ppm_pkg::chan_item_t pop_item
);
    import ppm_pkg::*;

    chan_item_t  mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[sv/ppm_back.sv]
// Back end: clamps, grades and scales each channel pulse into a result.
module ppm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ppm_pkg::cfg_t       cfg,
    input  logic                q_valid,
    input  ppm_pkg::chan_item_t q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output ppm_pkg::result_t    result
);
    import ppm_pkg::*;

    logic                  a_valid_reg;
    logic                  a_valid_next;
    logic [CHAN_BITS-1:0]  a_chan_reg;
    logic [REG_BITS-1:0]   a_raw_reg;
    logic [REG_BITS-1:0]   a_clamp_reg;
    logic                  a_below_reg;
    logic                  a_sat_reg;
    logic [DIFF_BITS-1:0]  a_diff_reg;
    switch_t               a_sw_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               result_reg;

    logic [CMP_BITS-1:0]   w_ext;
    logic [CMP_BITS-1:0]   lo_ext;
    logic [CMP_BITS-1:0]   hi_ext;
    logic [CMP_BITS-1:0]   c_high;
    logic [CMP_BITS-1:0]   c_both;
    logic [CMP_BITS-1:0]   diff;
    switch_t               sw;
    logic [PROD_BITS-1:0]  prod;
    logic [POS_BITS-1:0]   quot;
    logic                  out_load;
    logic                  a_load;

    assign out_load = a_valid_reg && (!out_valid_reg || out_ready);
    assign a_load   = q_valid && (!a_valid_reg || out_load);
    assign q_pop    = a_load;

    always_comb
    begin
        w_ext  = CMP_BITS'(q_item.width);
        lo_ext = CMP_BITS'(cfg.clamp_low);
        hi_ext = CMP_BITS'(cfg.clamp_high);
        c_high = (w_ext > hi_ext) ? hi_ext : w_ext;
        c_both = (c_high < lo_ext) ? lo_ext : c_high;
        diff   = c_both - lo_ext;
        if (w_ext < CMP_BITS'(cfg.switch_low))
            sw = SW_DOWN;
        else if (w_ext < CMP_BITS'(cfg.switch_high))
            sw = SW_MIDDLE;
        else
            sw = SW_UP;
    end

    always_comb
    begin
        prod = PROD_BITS'(a_diff_reg) * PROD_BITS'(POS_RECIP);
        quot = prod[POS_SHIFT +: POS_BITS];
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_load)
            a_valid_next = 1'b1;
        else if (out_load)
            a_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_chan_reg  <= q_item.channel;
            a_raw_reg   <= REG_BITS'(q_item.width);
            a_clamp_reg <= REG_BITS'(c_both);
            a_below_reg <= w_ext < lo_ext;
            a_sat_reg   <= diff >= CMP_BITS'(POS_SAT);
            a_diff_reg  <= DIFF_BITS'(diff);
            a_sw_reg    <= sw;
        end
        if (out_load)
        begin
            result_reg.channel       <= a_chan_reg;
            result_reg.raw_width     <= a_raw_reg;
            result_reg.clamped_width <= a_clamp_reg;
            result_reg.below_low     <= a_below_reg;
            result_reg.position      <= a_sat_reg ? POS_BITS'(POS_MAX) : quot;
            result_reg.switch_state  <= a_sw_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule
